// ===== design/utf8_to_bmp_code_unit_decoder_core_macros.svh =====
// Assertion macros for the UTF-8 to BMP decoder RTL.
`ifndef UTF8_TO_BMP_CODE_UNIT_DECODER_CORE_MACROS_SVH
`define UTF8_TO_BMP_CODE_UNIT_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define U2B_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);
// Check that a condition is followed by a consequence in the next cycle.
`define U2B_ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cause) |=> (effect)) else $error(msg);
`else
`define U2B_ASSERT_ALWAYS(label, expr, msg)
`define U2B_ASSERT_NEXT(label, cause, effect, msg)
`endif

`endif

// ===== design/u2b_pkg.sv =====
// Types, constants and helpers for the UTF-8 to BMP code unit decoder.
package u2b_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned UnitW    = 16;
    localparam int unsigned PartialW = 21;
    localparam int unsigned OwedW    = 2;

    localparam logic [OwedW-1:0] OwedNone = 2'd0;
    localparam logic [OwedW-1:0] OwedOne  = 2'd1;
    localparam logic [OwedW-1:0] OwedTwo  = 2'd2;
    localparam logic [OwedW-1:0] OwedThree = 2'd3;

    // Top five bits of a surrogate code unit (0xD800..0xDFFF).
    localparam logic [4:0] SurrogateTop = 5'b11011;

    typedef struct packed {
        logic [OwedW-1:0]    owed;
        logic [PartialW-1:0] partial;
        logic                emit;
        logic [UnitW-1:0]    unit;
    } step_t;

    // Value is nonzero, fits in 16 bits and is not a surrogate.
    function automatic logic bmp_ok(input logic [PartialW-1:0] v);
        bmp_ok = (v != '0) && (v[PartialW-1:UnitW] == '0)
                 && (v[UnitW-1:11] != SurrogateTop);
    endfunction

endpackage

// ===== design/u2b_step.sv =====
// Per-byte decode step: next sequence state and the emitted code unit.
module u2b_step (
    input  logic [u2b_pkg::ByteW-1:0]    byte_in,
    input  logic                         last_byte,
    input  logic [u2b_pkg::OwedW-1:0]    owed,
    input  logic [u2b_pkg::PartialW-1:0] partial,
    output u2b_pkg::step_t               step
);
    import u2b_pkg::*;

    logic                is_cont;
    logic [PartialW-1:0] merged;
    logic [OwedW-1:0]    owed_dec;

    assign is_cont  = (byte_in[7:6] == 2'b10);
    assign merged   = {partial[PartialW-7:0], byte_in[5:0]};
    assign owed_dec = owed - OwedOne;

    always_comb
    begin
        step.owed    = OwedNone;
        step.partial = '0;
        step.emit    = 1'b0;
        step.unit    = merged[UnitW-1:0];
        if ((owed != OwedNone) && is_cont)
        begin
            // Collect six more bits; finish when nothing else is owed.
            if (owed_dec == OwedNone)
            begin
                step.emit = bmp_ok(merged);
            end
            else
            begin
                step.owed    = owed_dec;
                step.partial = merged;
            end
        end
        else
        begin
            // Drop any pending lead and decode this byte as a new lead.
            step.unit = {{(UnitW-ByteW){1'b0}}, byte_in};
            unique case (byte_in) inside
                [8'h00:8'h7F]:
                begin
                    step.emit = (byte_in != '0);
                end
                [8'hC0:8'hDF]:
                begin
                    step.owed    = OwedOne;
                    step.partial = {{(PartialW-5){1'b0}}, byte_in[4:0]};
                end
                [8'hE0:8'hEF]:
                begin
                    step.owed    = OwedTwo;
                    step.partial = {{(PartialW-4){1'b0}}, byte_in[3:0]};
                end
                [8'hF0:8'hF7]:
                begin
                    step.owed    = OwedThree;
                    step.partial = {{(PartialW-3){1'b0}}, byte_in[2:0]};
                end
                default:
                begin
                    // Stray continuation or invalid lead: skip.
                    step.owed = OwedNone;
                end
            endcase
        end
        if (last_byte)
        begin
            step.owed    = OwedNone;
            step.partial = '0;
        end
    end

endmodule

// ===== design/utf8_to_bmp_code_unit_decoder_core.sv =====
// Top level of the UTF-8 to BMP code unit decoder.
// Takes one UTF-8 byte per cycle and returns a 16-bit BMP code unit for each
// completed character in 1..0xFFFF outside the surrogates; other values,
// stray and invalid bytes, and a sequence cut short by last_byte yield
// nothing. Each byte passes an input register, then one decode step against
// the sequence state into the output register: an accepted byte waits in the
// input register until the output register is free, and a new byte is accepted
// every cycle while the output side keeps taking beats.
`include "utf8_to_bmp_code_unit_decoder_core_macros.svh"

module utf8_to_bmp_code_unit_decoder_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [u2b_pkg::ByteW-1:0]    byte_in,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [u2b_pkg::UnitW-1:0]    code_unit
);
    import u2b_pkg::*;

    logic                in_valid_reg;
    logic [ByteW-1:0]    byte_reg;
    logic                last_reg;
    logic [OwedW-1:0]    owed_reg;
    logic [PartialW-1:0] partial_reg;
    logic                out_valid_reg;
    logic [UnitW-1:0]    unit_reg;

    logic                out_free;
    logic                advance;
    step_t               step;

    u2b_step u_step (
        .byte_in   (byte_reg),
        .last_byte (last_reg),
        .owed      (owed_reg),
        .partial   (partial_reg),
        .step      (step)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign code_unit = unit_reg;

    // Input register: take a new beat whenever none is held or the held one moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_in;
            last_reg <= last_byte;
        end
    end

    // Sequence state advances once per decoded byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg    <= OwedNone;
            partial_reg <= '0;
        end
        else if (advance)
        begin
            owed_reg    <= step.owed;
            partial_reg <= step.partial;
        end
    end

    // Output register: load on an emitting byte, clear once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && step.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step.emit)
        begin
            unit_reg <= step.unit;
        end
    end

    `U2B_ASSERT_ALWAYS(a_idle_partial_clear,
        (owed_reg != OwedNone) || (partial_reg == '0),
        "partial value left over with nothing owed")
    `U2B_ASSERT_ALWAYS(a_partial_bounded,
        ((owed_reg != OwedThree) || (partial_reg[PartialW-1:3] == '0))
        && ((owed_reg != OwedTwo) || (partial_reg[PartialW-1:9] == '0))
        && ((owed_reg != OwedOne) || (partial_reg[PartialW-1:15] == '0)),
        "partial value wider than its owed count allows")
    `U2B_ASSERT_ALWAYS(a_unit_legal,
        !out_valid_reg
        || ((unit_reg != '0) && (unit_reg[UnitW-1:11] != SurrogateTop)),
        "emitted code unit is zero or a surrogate")
    `U2B_ASSERT_NEXT(a_last_clears,
        advance && last_reg,
        (owed_reg == OwedNone) && (partial_reg == '0),
        "sequence state not cleared after last byte")
    `U2B_ASSERT_NEXT(a_held_result,
        out_valid_reg && !out_ready,
        out_valid_reg && $stable(unit_reg),
        "pending result lost or changed while stalled")

endmodule
